[rtl/ecomp_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the e-compass core.
// Depends on nothing; every other file imports it.
`default_nettype none

package ecomp_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 7;
   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF     = 4;

   // Angle accumulator: degrees with 16 fraction bits
   localparam int ACC_FRAC = 16;
   localparam int ACC_Z_W  = 26;
   // Vector datapath: 17-bit operand scaled by 2^16, CORDIC gain and sign headroom
   localparam int OP_W     = 17;
   localparam int CORDIC_W = 35;
   localparam int TABLE_LEN = 24;

   localparam logic signed [ACC_Z_W-1:0] DEG90_ACC = ACC_Z_W'(90 * 65536);

   typedef enum logic [1:0] {
      QUAD_NONE,
      QUAD_POS90,
      QUAD_NEG90
   } quad_type;

   // One atan2 operand pair after the quadrant pre-rotation
   typedef struct packed {
      logic signed [OP_W-1:0] x;
      logic signed [OP_W-1:0] y;
      quad_type               quad;
      logic                   zero;
   } vec_op_type;

   typedef struct packed {
      vec_op_type head;
      vec_op_type roll;
      vec_op_type pitch;
   } ecomp_item_type;

   // atan(2^-i) in degrees * 2^16
   function automatic logic signed [ACC_Z_W-1:0] atan_deg(input int idx);
      logic signed [ACC_Z_W-1:0] v;
      unique case (idx)
         0:       v = ACC_Z_W'(2949120);
         1:       v = ACC_Z_W'(1740967);
         2:       v = ACC_Z_W'(919879);
         3:       v = ACC_Z_W'(466945);
         4:       v = ACC_Z_W'(234379);
         5:       v = ACC_Z_W'(117304);
         6:       v = ACC_Z_W'(58666);
         7:       v = ACC_Z_W'(29335);
         8:       v = ACC_Z_W'(14668);
         9:       v = ACC_Z_W'(7334);
         10:      v = ACC_Z_W'(3667);
         11:      v = ACC_Z_W'(1833);
         12:      v = ACC_Z_W'(917);
         13:      v = ACC_Z_W'(458);
         14:      v = ACC_Z_W'(229);
         15:      v = ACC_Z_W'(115);
         16:      v = ACC_Z_W'(57);
         17:      v = ACC_Z_W'(29);
         18:      v = ACC_Z_W'(14);
         19:      v = ACC_Z_W'(7);
         20:      v = ACC_Z_W'(4);
         21:      v = ACC_Z_W'(2);
         22:      v = ACC_Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/ecompass_orientation_core.sv]
// E-compass core: heading, roll and pitch by pipelined CORDIC atan2.
// An accepted transaction loads the front register, then moves through the queue, one stage per
// micro-rotation and the result register; the back end stalls on a waiting result.
// Throughput one transaction per cycle while rsp_ready is high; the lanes are fully pipelined.
// Synchronous reset empties the front register, the queue and the pipeline valid bits.
// Depends on ecomp_pkg, ecomp_front, ecomp_queue, ecomp_back.
`default_nettype none

module ecompass_orientation_core
   import ecomp_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [15:0]    req_accel_x_word,
   input  wire logic [15:0]    req_accel_y_word,
   input  wire logic [15:0]    req_accel_z_word,
   input  wire logic [15:0]    req_mag_x_word,
   input  wire logic [15:0]    req_mag_y_word,
   input  wire logic [15:0]    req_mag_z_word,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic signed [15:0]  rsp_heading_deg,
   output logic signed [15:0]  rsp_roll_deg,
   output logic signed [15:0]  rsp_pitch_deg
);

   logic           push_valid, push_ready;
   ecomp_item_type push_item, queue_item;
   logic           queue_valid, queue_pop;

   ecomp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_accel_x_word(req_accel_x_word),
      .req_accel_y_word(req_accel_y_word),
      .req_accel_z_word(req_accel_z_word),
      .req_mag_x_word  (req_mag_x_word),
      .req_mag_y_word  (req_mag_y_word),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   ecomp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_item  (push_item),
      .out_valid(queue_valid),
      .out_pop  (queue_pop),
      .out_item (queue_item)
   );

   ecomp_back #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .CORDIC_STEPS   (CORDIC_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (queue_valid),
      .item_pop       (queue_pop),
      .item           (queue_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_heading_deg(rsp_heading_deg),
      .rsp_roll_deg   (rsp_roll_deg),
      .rsp_pitch_deg  (rsp_pitch_deg)
   );

endmodule

`default_nettype wire

[rtl/ecomp_front.sv]
// Front end: accepts raw sensor transactions, extends them and classifies each
// atan2 operand pair by quadrant. Depends on ecomp_pkg.
`default_nettype none

module ecomp_front
   import ecomp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [15:0]    req_accel_x_word,
   input  wire logic [15:0]    req_accel_y_word,
   input  wire logic [15:0]    req_accel_z_word,
   input  wire logic [15:0]    req_mag_x_word,
   input  wire logic [15:0]    req_mag_y_word,
   output logic                push_valid,
   input  wire logic           push_ready,
   output ecomp_item_type      push_item
);

   logic           front_valid_ff, front_valid_in;
   ecomp_item_type front_item_ff, front_item_in;
   logic signed [OP_W-1:0] ax, ay, az, mx, my;

   // Rotate left half-plane vectors by -/+90 degrees into the right half-plane
   function automatic vec_op_type classify(input logic signed [OP_W-1:0] x,
                                           input logic signed [OP_W-1:0] y);
      vec_op_type op;
      op.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         if (y >= 0) begin
            op.x    = y;
            op.y    = -x;
            op.quad = QUAD_POS90;
         end else begin
            op.x    = -y;
            op.y    = x;
            op.quad = QUAD_NEG90;
         end
      end else begin
         op.x    = x;
         op.y    = y;
         op.quad = QUAD_NONE;
      end
      return op;
   endfunction

   // Accelerometer words are left-justified 14-bit
   assign ax = {{3{req_accel_x_word[15]}}, req_accel_x_word[15:2]};
   assign ay = {{3{req_accel_y_word[15]}}, req_accel_y_word[15:2]};
   assign az = {{3{req_accel_z_word[15]}}, req_accel_z_word[15:2]};
   assign mx = {req_mag_x_word[15], req_mag_x_word};
   assign my = {req_mag_y_word[15], req_mag_y_word};

   assign req_ready  = !front_valid_ff || push_ready;
   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

   always_comb begin
      front_item_in.head  = classify(mx, my);
      front_item_in.roll  = classify(az, ax);
      front_item_in.pitch = classify(az, ay);
      front_valid_in = front_valid_ff;
      if (req_valid && req_ready) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         front_item_ff <= front_item_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ecomp_queue.sv]
// Short queue of classified transactions between the front end and the CORDIC back end.
// Depends on ecomp_pkg.
`default_nettype none

module ecomp_queue
   import ecomp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  ecomp_item_type      in_item,
   output logic                out_valid,
   input  wire logic           out_pop,
   output ecomp_item_type      out_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ecomp_item_type   entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

[rtl/ecomp_cordic_lane.sv]
// One pipelined vectoring CORDIC lane, one micro-rotation per stage, angle in
// degrees with 16 fraction bits. Depends on ecomp_pkg.
`default_nettype none

module ecomp_cordic_lane
   import ecomp_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  en,
   input  vec_op_type                 op_in,
   output logic signed [ACC_Z_W-1:0]  z_out,
   output logic                       zero_out
);

   logic signed [CORDIC_W-1:0] x_src [STEPS];
   logic signed [CORDIC_W-1:0] y_src [STEPS];
   logic signed [ACC_Z_W-1:0]  z_src [STEPS];
   logic                       zero_src [STEPS];
   logic signed [CORDIC_W-1:0] x_in [STEPS];
   logic signed [CORDIC_W-1:0] y_in [STEPS];
   logic signed [ACC_Z_W-1:0]  z_in [STEPS];
   logic signed [CORDIC_W-1:0] x_ff [STEPS];
   logic signed [CORDIC_W-1:0] y_ff [STEPS];
   logic signed [ACC_Z_W-1:0]  z_ff [STEPS];
   logic                       zero_ff [STEPS];
   logic signed [ACC_Z_W-1:0]  z_init;

   always_comb begin
      unique case (op_in.quad)
         QUAD_POS90: z_init = DEG90_ACC;
         QUAD_NEG90: z_init = -DEG90_ACC;
         default:    z_init = '0;
      endcase
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] xs, ys;

      if (i == 0) begin : g_first
         assign x_src[i] = {{(CORDIC_W-OP_W-ACC_FRAC){op_in.x[OP_W-1]}}, op_in.x,
                            {ACC_FRAC{1'b0}}};
         assign y_src[i] = {{(CORDIC_W-OP_W-ACC_FRAC){op_in.y[OP_W-1]}}, op_in.y,
                            {ACC_FRAC{1'b0}}};
         assign z_src[i]    = z_init;
         assign zero_src[i] = op_in.zero;
      end else begin : g_next
         assign x_src[i]    = x_ff[i-1];
         assign y_src[i]    = y_ff[i-1];
         assign z_src[i]    = z_ff[i-1];
         assign zero_src[i] = zero_ff[i-1];
      end

      assign xs = x_src[i] >>> i;
      assign ys = y_src[i] >>> i;

      // Rotate toward the x axis; the sign of y picks the direction
      always_comb begin
         if (y_src[i] >= 0) begin
            x_in[i] = x_src[i] + ys;
            y_in[i] = y_src[i] - xs;
            z_in[i] = z_src[i] + atan_deg(i);
         end else begin
            x_in[i] = x_src[i] - ys;
            y_in[i] = y_src[i] + xs;
            z_in[i] = z_src[i] - atan_deg(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            zero_ff[i] <= zero_src[i];
         end
      end
   end

   assign z_out    = z_ff[STEPS-1];
   assign zero_out = zero_ff[STEPS-1] | (x_ff[STEPS-1] == '0 && zero_ff[STEPS-1]);

endmodule

`default_nettype wire

[rtl/ecomp_back.sv]
// Back end: three CORDIC lanes in lockstep, then rounding, heading offset and
// wrap, tilt clamp and the result register. Depends on ecomp_pkg, ecomp_cordic_lane.
`default_nettype none

module ecomp_back
   import ecomp_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           item_valid,
   output logic                item_pop,
   input  ecomp_item_type      item,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic signed [15:0]  rsp_heading_deg,
   output logic signed [15:0]  rsp_roll_deg,
   output logic signed [15:0]  rsp_pitch_deg
);

   localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int ANG_W = ACC_Z_W + 1;
   localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(64'sd1 << (SH - 1));
   localparam logic signed [ANG_W-1:0] OFS90    = ANG_W'(90 << ANGLE_FRAC_BITS);
   localparam logic signed [ANG_W-1:0] LIM180   = ANG_W'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [ANG_W-1:0] FULL360  = ANG_W'(360 << ANGLE_FRAC_BITS);

   logic                      en;
   logic [CORDIC_STEPS-1:0]   vld_ff, vld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]        head_ff, roll_ff, pitch_ff;
   logic signed [15:0]        head_in, roll_in, pitch_in;
   logic signed [ACC_Z_W-1:0] head_z, roll_z, pitch_z;
   logic                      head_zero, roll_zero, pitch_zero;
   logic signed [ANG_W-1:0]   head_r, roll_r, pitch_r, head_sum;
   logic signed [ANG_W-1:0]   roll_c, pitch_c;

   // Round to nearest, halves up; a zero vector gives a zero angle
   function automatic logic signed [ANG_W-1:0] rnd(input logic signed [ACC_Z_W-1:0] z,
                                                   input logic zero);
      logic signed [ANG_W-1:0] s;
      s = zero ? HALF_LSB : (ANG_W'(z) + HALF_LSB);
      return s >>> SH;
   endfunction

   function automatic logic signed [ANG_W-1:0] clamp(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W-1:0] c;
      priority if (v > LIM180) begin
         c = LIM180;
      end else if (v < -LIM180) begin
         c = -LIM180;
      end else begin
         c = v;
      end
      return c;
   endfunction

   // Whole pipeline advances together; hold while the result waits
   assign en       = !rsp_valid_ff || rsp_ready;
   assign item_pop = en;

   ecomp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_head (
      .clock(clock), .en(en), .op_in(item.head), .z_out(head_z), .zero_out(head_zero)
   );
   ecomp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock(clock), .en(en), .op_in(item.roll), .z_out(roll_z), .zero_out(roll_zero)
   );
   ecomp_cordic_lane #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .en(en), .op_in(item.pitch), .z_out(pitch_z), .zero_out(pitch_zero)
   );

   always_comb begin
      vld_in = vld_ff;
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         vld_in       = {vld_ff[CORDIC_STEPS-2:0], item_valid};
         rsp_valid_in = vld_ff[CORDIC_STEPS-1];
      end

      head_r   = rnd(head_z, head_zero);
      roll_r   = rnd(roll_z, roll_zero);
      pitch_r  = rnd(pitch_z, pitch_zero);
      head_sum = head_r + OFS90;
      if (head_sum >= LIM180) begin
         head_sum = head_sum - FULL360;
      end
      roll_c   = clamp(roll_r);
      pitch_c  = clamp(pitch_r);
      head_in  = head_sum[15:0];
      roll_in  = roll_c[15:0];
      pitch_in = pitch_c[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         head_ff  <= head_in;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading_deg = head_ff;
   assign rsp_roll_deg    = roll_ff;
   assign rsp_pitch_deg   = pitch_ff;

endmodule

`default_nettype wire

[sim/ecompass_orientation_core_tb.sv]
// Testbench for ecompass_orientation_core: directed and random sensor word sets,
// results checked field by field against typed values or an in-bench CORDIC orientation predictor.
// Depends on ecomp_pkg and the RTL of ecompass_orientation_core.
`default_nettype none

module ecompass_orientation_core_tb
   import ecomp_pkg::*;
();

   localparam int    NUM_RANDOM   = 1330;
   localparam int    DRAIN_CYCLES = 40;
   localparam int    HOLD_CYCLES  = 160;
   localparam int    HOLD_AT      = 400;
   localparam int    PAUSE_AT     = 700;
   localparam int    ROUND_SHIFT  = ACC_FRAC - ANGLE_FRAC_BITS_DEF;
   localparam longint DEG90_FX    = 64'sd90 << ACC_FRAC;
   localparam longint HEAD_OFFSET = 64'sd90 << ANGLE_FRAC_BITS_DEF;
   localparam longint HALF_TURN   = 64'sd180 << ANGLE_FRAC_BITS_DEF;
   localparam longint FULL_TURN   = 64'sd360 << ANGLE_FRAC_BITS_DEF;

   // atan(2^-i) in degrees with 16 fraction bits
   localparam longint ATAN_STEP_DEG [TABLE_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct {
      logic signed [15:0] heading;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
   } angles_type;

   typedef struct {
      logic [15:0]        ax;
      logic [15:0]        ay;
      logic [15:0]        az;
      logic [15:0]        mx;
      logic [15:0]        my;
      logic [15:0]        mz;
      bit                 typed;
      logic signed [15:0] heading;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
   } sample_row_type;

   localparam int NUM_DIRECTED = 18;

   // ax, ay, az, mx, my, mz, typed, heading, roll, pitch
   sample_row_type directed_rows [NUM_DIRECTED] = '{
      // all zero: every atan2 is zero, heading sits at 90
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'sd11520, 16'sd0, 16'sd0},
      // accel low bits vanish in the shift, so still atan2(0, 0)
      '{16'h0003, 16'h0003, 16'h0003, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'sd11520, 16'sd0, 16'sd0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      // negative x with zero y
      '{16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h1234, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h0000, 16'hFFFC, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h0000, 16'h7FFC, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h7FFC, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h8000, 16'h7FFC, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      // heading wrap on both sides of the half turn
      '{16'h0004, 16'hFFFC, 16'h8000, 16'h8000, 16'h0001, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'hFFFC, 16'h0004, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h0000, 16'hFFFC, 16'hFFFF, 16'h0001, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h0000, 16'hFFFC, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0004, 16'hFFFC, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h7FFC, 16'h8000, 16'h0004, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h1234, 16'hEDCB, 16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5, 1'b0, 16'sd0, 16'sd0, 16'sd0},
      '{16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333, 16'hF0F0, 16'h0F0F, 1'b0, 16'sd0, 16'sd0, 16'sd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_accel_x_word = '0;
   logic [15:0]        req_accel_y_word = '0;
   logic [15:0]        req_accel_z_word = '0;
   logic [15:0]        req_mag_x_word = '0;
   logic [15:0]        req_mag_y_word = '0;
   logic [15:0]        req_mag_z_word = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_heading_deg;
   logic signed [15:0] rsp_roll_deg;
   logic signed [15:0] rsp_pitch_deg;

   angles_type pending_angles [$];
   int         mismatch_count = 0;
   int         results_seen = 0;

   ecompass_orientation_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_accel_x_word (req_accel_x_word),
      .req_accel_y_word (req_accel_y_word),
      .req_accel_z_word (req_accel_z_word),
      .req_mag_x_word   (req_mag_x_word),
      .req_mag_y_word   (req_mag_y_word),
      .req_mag_z_word   (req_mag_z_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heading_deg  (rsp_heading_deg),
      .rsp_roll_deg     (rsp_roll_deg),
      .rsp_pitch_deg    (rsp_pitch_deg)
   );

   always #4 clock = ~clock;

   // atan2(y, x) in degrees with 16 fraction bits, vectoring CORDIC
   function automatic longint cordic_atan2_deg(input longint y_in, input longint x_in);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0)
         return 0;
      // pre-rotate the left half plane by a quarter turn
      if (x < 0) begin
         if (y >= 0) begin
            x = y_in;
            y = -x_in;
            z = DEG90_FX;
         end else begin
            x = -y_in;
            y = x_in;
            z = -DEG90_FX;
         end
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < CORDIC_STEPS_DEF && i < TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP_DEG[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP_DEG[i];
         end
      end
      return z;
   endfunction

   function automatic longint round_deg(input longint z);
      return (z + (64'sd1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
   endfunction

   function automatic longint clamp_half_turn(input longint v);
      if (v > HALF_TURN)
         return HALF_TURN;
      if (v < -HALF_TURN)
         return -HALF_TURN;
      return v;
   endfunction

   function automatic angles_type predict_orientation(input logic [15:0] ax_w,
                                                      input logic [15:0] ay_w,
                                                      input logic [15:0] az_w,
                                                      input logic [15:0] mx_w,
                                                      input logic [15:0] my_w);
      angles_type a;
      longint     ax;
      longint     ay;
      longint     az;
      longint     mx;
      longint     my;
      longint     head;
      ax = longint'($signed(ax_w)) >>> 2;
      ay = longint'($signed(ay_w)) >>> 2;
      az = longint'($signed(az_w)) >>> 2;
      mx = longint'($signed(mx_w));
      my = longint'($signed(my_w));
      // wrap after rounding
      head = round_deg(cordic_atan2_deg(my, mx)) + HEAD_OFFSET;
      if (head >= HALF_TURN)
         head = head - FULL_TURN;
      a.heading = 16'(head);
      a.roll    = 16'(clamp_half_turn(round_deg(cordic_atan2_deg(ax, az))));
      a.pitch   = 16'(clamp_half_turn(round_deg(cordic_atan2_deg(ay, az))));
      return a;
   endfunction

   function automatic logic [15:0] draw_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         3: return 16'($urandom_range(0, 1023)) << $urandom_range(0, 6);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
                  $signed(exp_v), $signed(act_v));
         mismatch_count++;
      end
   endtask

   // Drive one sample set; return after the transaction is accepted.
   task automatic send_sample(input sample_row_type row, input bit with_gaps);
      int         gap;
      angles_type exp_a;
      gap = with_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_accel_x_word <= row.ax;
      req_accel_y_word <= row.ay;
      req_accel_z_word <= row.az;
      req_mag_x_word   <= row.mx;
      req_mag_y_word   <= row.my;
      req_mag_z_word   <= row.mz;
      do @(posedge clock); while (!req_ready);
      if (row.typed) begin
         exp_a.heading = row.heading;
         exp_a.roll    = row.roll;
         exp_a.pitch   = row.pitch;
      end else begin
         exp_a = predict_orientation(row.ax, row.ay, row.az, row.mx, row.my);
      end
      pending_angles.push_back(exp_a);
   endtask

   // sender
   initial begin
      sample_row_type row;
      int             n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (n = 0; n < NUM_DIRECTED; n++)
         send_sample(directed_rows[n], 1'b1);
      for (n = 0; n < NUM_RANDOM; n++) begin
         // hold off until the pipeline has drained completely
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_angles.size() != 0);
         end
         row.ax    = draw_word();
         row.ay    = draw_word();
         row.az    = draw_word();
         row.mx    = draw_word();
         row.my    = draw_word();
         row.mz    = 16'($urandom());
         row.typed = 1'b0;
         send_sample(row, (n / 150) % 3 != 1);
      end
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // receiver
   initial begin
      int         stall;
      angles_type exp_a;
      bit         held;
      held = 1'b0;
      wait (!reset);
      forever begin
         if (!held && results_seen == HOLD_AT) begin
            stall = HOLD_CYCLES;
            held  = 1'b1;
         end else if ((results_seen / 200) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual %0d %0d %0d",
                     $time, rsp_heading_deg, rsp_roll_deg, rsp_pitch_deg);
            mismatch_count++;
         end else begin
            exp_a = pending_angles.pop_front();
            check_field("heading", exp_a.heading, rsp_heading_deg);
            check_field("roll", exp_a.roll, rsp_roll_deg);
            check_field("pitch", exp_a.pitch, rsp_pitch_deg);
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
